// ===== rtl/core/hcm_pkg.sv =====
package hcm_pkg;

  localparam int MAX_ORDER_DEF = 16;
  localparam int ORDER_W       = 5;
  localparam int COORD_W       = 16;
  localparam int POS_W         = 32;
  localparam int LEVEL_W       = 4;
  localparam int LEVELS_PER_STAGE = 4;
  localparam logic [ORDER_W-1:0] ORDER_RESET = 5'd5;

  typedef enum logic {
    ACT_XY2D = 1'b0,
    ACT_D2XY = 1'b1
  } hcm_action_t;

  typedef struct packed {
    hcm_action_t        action;
    logic [COORD_W-1:0] row_in;
    logic [COORD_W-1:0] col_in;
    logic [POS_W-1:0]   position_in;
  } hcm_in_t;

  typedef struct packed {
    logic [POS_W-1:0]   position_out;
    logic [COORD_W-1:0] row_out;
    logic [COORD_W-1:0] col_out;
    logic               out_of_range;
  } hcm_out_t;

  // in-flight item: unused fields are cleared at entry and filled level by level
  typedef struct packed {
    hcm_action_t        action;
    logic               oor;
    logic               fa;
    logic               fb;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [POS_W-1:0]   pos;
  } hcm_work_t;

  // transpose swaps odd steps, anti-transpose swaps even steps
  function automatic logic [1:0] hcm_relabel(logic [1:0] q, logic fa, logic fb);
    logic swap;
    swap = (fa & q[0]) | (fb & ~q[0]);
    return q ^ {swap, 1'b0};
  endfunction

  function automatic hcm_work_t hcm_level(hcm_work_t w, logic [LEVEL_W-1:0] t);
    hcm_work_t  res;
    logic [1:0] q;
    logic [1:0] r;
    res = w;
    if (w.action == ACT_XY2D) begin
      q = {w.row[t], w.row[t] ^ w.col[t]};
      r = hcm_relabel(q, w.fa, w.fb);
      res.pos[{t, 1'b0} +: 2] = r;
    end else begin
      r = w.pos[{t, 1'b0} +: 2];
      q = hcm_relabel(r, w.fa, w.fb);
      res.row[t] = q[1];
      res.col[t] = q[1] ^ q[0];
    end
    if (r == 2'd0) res.fa = ~w.fa;
    if (r == 2'd3) res.fb = ~w.fb;
    return res;
  endfunction

endpackage

// ===== rtl/core/hilbert_curve_2d_mapper.sv =====
// channel   dir  handshake             payload
// in_       in   in_valid/in_ready     hcm_in_t: action, row_in, col_in, position_in
// out_      out  out_valid/out_ready   hcm_out_t: position_out, row_out, col_out, out_of_range
// cfg_      in   cfg_valid/cfg_ready   curve_order, 5 bits (cfg_ready is always high)
//
// one transaction per cycle while the output is not stalled; min(MAX_ORDER,16) curve levels are
// split into pipeline stages of four curve levels per stage, between entry and output registers
// synchronous active-low reset empties the pipeline and sets curve_order to 5
// a stall holds each full stage; empty stages still fill behind it
module hilbert_curve_2d_mapper #(
  parameter int MAX_ORDER = hcm_pkg::MAX_ORDER_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  hcm_pkg::hcm_in_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output hcm_pkg::hcm_out_t           out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [hcm_pkg::ORDER_W-1:0] cfg_data
);

  localparam int LEVELS = (MAX_ORDER < 1) ? 1 : ((MAX_ORDER > 16) ? 16 : MAX_ORDER);
  localparam int NST    = (LEVELS + hcm_pkg::LEVELS_PER_STAGE - 1) / hcm_pkg::LEVELS_PER_STAGE;

  logic [hcm_pkg::ORDER_W-1:0] order_r;
  logic                        vld     [NST+1];
  logic                        rdy     [NST+1];
  hcm_pkg::hcm_work_t          work    [NST+1];
  logic                        out_valid_r;
  hcm_pkg::hcm_out_t           out_nxt;
  hcm_pkg::hcm_out_t           out_r;
  logic                        last_ready;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= hcm_pkg::ORDER_RESET;
    end else if (cfg_valid && cfg_ready) begin
      order_r <= cfg_data;
    end
  end

  hcm_entry_stage #(
    .LEVELS (LEVELS)
  ) u_entry (
    .clk       (clk),
    .rst_n     (rst_n),
    .order     (order_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (vld[0]),
    .out_ready (rdy[0]),
    .out_work  (work[0])
  );

  for (genvar k = 0; k < NST; k++) begin : g_lvl
    localparam int Hi  = LEVELS - 1 - hcm_pkg::LEVELS_PER_STAGE * k;
    localparam int Cnt = (Hi + 1 < hcm_pkg::LEVELS_PER_STAGE) ? Hi + 1
                                                              : hcm_pkg::LEVELS_PER_STAGE;
    hcm_level_stage #(
      .HI  (Hi),
      .CNT (Cnt)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_work   (work[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_work  (work[k+1])
    );
  end

  // output register: zero the fields the action does not produce, or all on a flag
  always_comb begin
    out_nxt              = '0;
    out_nxt.out_of_range = work[NST].oor;
    if (!work[NST].oor) begin
      if (work[NST].action == hcm_pkg::ACT_XY2D) begin
        out_nxt.position_out = work[NST].pos;
      end else begin
        out_nxt.row_out = work[NST].row;
        out_nxt.col_out = work[NST].col;
      end
    end
  end

  assign last_ready = ~out_valid_r | out_ready;
  assign rdy[NST]   = last_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (last_ready) begin
      out_valid_r <= vld[NST];
    end
    if (vld[NST] && last_ready) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// ===== rtl/core/hcm_entry_stage.sv =====
module hcm_entry_stage #(
  parameter int LEVELS = hcm_pkg::MAX_ORDER_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [hcm_pkg::ORDER_W-1:0]  order,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  hcm_pkg::hcm_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output hcm_pkg::hcm_work_t           out_work
);

  localparam logic LevelsOdd = LEVELS[0];

  logic [hcm_pkg::ORDER_W-1:0] eff;
  logic                        row_oor;
  logic                        col_oor;
  logic                        pos_oor;
  hcm_pkg::hcm_work_t          work_nxt;
  hcm_pkg::hcm_work_t          work_r;
  logic                        valid_r;

  always_comb begin
    eff = order;
    if (eff == '0) eff = hcm_pkg::ORDER_W'(1);
    if (eff > hcm_pkg::ORDER_W'(LEVELS)) eff = hcm_pkg::ORDER_W'(LEVELS);
  end

  assign row_oor = (in_data.row_in >> eff) != '0;
  assign col_oor = (in_data.col_in >> eff) != '0;
  assign pos_oor = (in_data.position_in >> {eff, 1'b0}) != '0;

  always_comb begin
    work_nxt.action = in_data.action;
    work_nxt.oor    = (in_data.action == hcm_pkg::ACT_D2XY) ? pos_oor : (row_oor | col_oor);
    // leading zero levels above the order flip fa once each, start so it is clear at the top
    work_nxt.fa     = LevelsOdd ^ eff[0];
    work_nxt.fb     = 1'b0;
    if (in_data.action == hcm_pkg::ACT_XY2D) begin
      work_nxt.row = in_data.row_in;
      work_nxt.col = in_data.col_in;
      work_nxt.pos = '0;
    end else begin
      work_nxt.row = '0;
      work_nxt.col = '0;
      work_nxt.pos = in_data.position_in;
    end
  end

  assign in_ready = ~valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

endmodule

// ===== rtl/core/hcm_level_stage.sv =====
module hcm_level_stage #(
  parameter int HI  = 15,
  parameter int CNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hcm_pkg::hcm_work_t in_work,
  output logic               out_valid,
  input  logic               out_ready,
  output hcm_pkg::hcm_work_t out_work
);

  hcm_pkg::hcm_work_t work_nxt;
  hcm_pkg::hcm_work_t work_r;
  logic               valid_r;

  // CNT levels, most significant first
  always_comb begin
    work_nxt = in_work;
    for (int j = 0; j < CNT; j++) begin
      work_nxt = hcm_pkg::hcm_level(work_nxt, hcm_pkg::LEVEL_W'(HI - j));
    end
  end

  assign in_ready = ~valid_r | out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      work_r <= work_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_work  = work_r;

endmodule

// ===== rtl/core/hcm_checker.sv =====
module hcm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input hcm_pkg::hcm_in_t            in_data,
  input logic                        out_valid,
  input logic                        out_ready,
  input hcm_pkg::hcm_out_t           out_data,
  input logic                        cfg_valid,
  input logic                        cfg_ready,
  input logic [hcm_pkg::ORDER_W-1:0] cfg_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // a flagged result carries no coordinates or position
  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.out_of_range |->
      out_data.position_out == '0 && out_data.row_out == '0 && out_data.col_out == '0)
    else $error("flagged result has nonzero fields");

  // a result is either a position or a cell, never both
  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.position_out != '0 |->
      out_data.row_out == '0 && out_data.col_out == '0)
    else $error("result holds both position and cell");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind hilbert_curve_2d_mapper hcm_checker u_hcm_checker (.*);

// ===== tb/hilbert_curve_2d_mapper_test.sv =====
module hilbert_curve_2d_mapper_test;

  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 250;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_PRINTS = 20;

  typedef struct {
    logic [hcm_pkg::ORDER_W-1:0] order;
    hcm_pkg::hcm_in_t            stim;
    bit                          known;
    hcm_pkg::hcm_out_t           res;
  } dir_row_t;

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  hcm_pkg::hcm_in_t            in_data;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  hcm_pkg::hcm_out_t           out_data;
  logic                        cfg_valid;
  logic                        cfg_ready;
  logic [hcm_pkg::ORDER_W-1:0] cfg_data;

  hcm_pkg::hcm_out_t           expected_results[$];
  dir_row_t                    dir_rows[$];
  logic [hcm_pkg::ORDER_W-1:0] cur_order;
  bit                          steady;
  int                          stall_left = 0;
  int                          errors = 0;
  int                          sent;
  int                          checked = 0;
  int                          flagged = 0;
  int                          cfg_writes;

  hilbert_curve_2d_mapper uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // order register value as the block uses it: 0 acts as 1, anything above the cap as the cap
  function automatic int grid_order(input logic [hcm_pkg::ORDER_W-1:0] raw);
    int lim;
    lim = (hcm_pkg::MAX_ORDER_DEF < 16) ? hcm_pkg::MAX_ORDER_DEF : 16;
    if (raw == 0) return 1;
    if (int'(raw) > lim) return lim;
    return int'(raw);
  endfunction

  // first-quadrant transpose swaps steps 1/3, last-quadrant anti-transpose swaps 0/2
  function automatic logic [1:0] swap_steps(input logic [1:0] q, input bit tr, input bit atr);
    if (tr && q[0]) q ^= 2'd2;
    if (atr && !q[0]) q ^= 2'd2;
    return q;
  endfunction

  function automatic hcm_pkg::hcm_out_t hilbert_convert(input hcm_pkg::hcm_in_t it,
                                                        input logic [hcm_pkg::ORDER_W-1:0] raw);
    hcm_pkg::hcm_out_t res;
    int                n;
    logic [16:0]       side;
    logic [32:0]       cells;
    logic [1:0]        q;
    logic [1:0]        r;
    bit                tr;
    bit                atr;
    n = grid_order(raw);
    side = 17'd1 << n;
    cells = 33'd1 << (2 * n);
    res = '0;
    tr = 0;
    atr = 0;
    if (it.action == hcm_pkg::ACT_XY2D) begin
      if ({1'b0, it.row_in} >= side || {1'b0, it.col_in} >= side) begin
        res.out_of_range = 1'b1;
      end else begin
        for (int t = n - 1; t >= 0; t--) begin
          q = it.row_in[t] ? (it.col_in[t] ? 2'd2 : 2'd3) : (it.col_in[t] ? 2'd1 : 2'd0);
          r = swap_steps(q, tr, atr);
          res.position_out = {res.position_out[hcm_pkg::POS_W-3:0], r};
          if (r == 2'd0) tr = !tr;
          if (r == 2'd3) atr = !atr;
        end
      end
    end else begin
      if ({1'b0, it.position_in} >= cells) begin
        res.out_of_range = 1'b1;
      end else begin
        for (int t = n - 1; t >= 0; t--) begin
          r = it.position_in[2 * t +: 2];
          q = swap_steps(r, tr, atr);
          res.row_out = {res.row_out[hcm_pkg::COORD_W-2:0], q[1]};
          res.col_out = {res.col_out[hcm_pkg::COORD_W-2:0], q[1] ^ q[0]};
          if (r == 2'd0) tr = !tr;
          if (r == 2'd3) atr = !atr;
        end
      end
    end
    return res;
  endfunction

  function automatic hcm_pkg::hcm_out_t outcome(input logic [hcm_pkg::POS_W-1:0] p,
                                                input logic [hcm_pkg::COORD_W-1:0] r,
                                                input logic [hcm_pkg::COORD_W-1:0] c,
                                                input logic f);
    hcm_pkg::hcm_out_t res;
    res.position_out = p;
    res.row_out = r;
    res.col_out = c;
    res.out_of_range = f;
    return res;
  endfunction

  task automatic add_row(input logic [hcm_pkg::ORDER_W-1:0] order,
                         input hcm_pkg::hcm_action_t act,
                         input logic [hcm_pkg::COORD_W-1:0] row,
                         input logic [hcm_pkg::COORD_W-1:0] col,
                         input logic [hcm_pkg::POS_W-1:0] pos, input bit known,
                         input hcm_pkg::hcm_out_t res);
    dir_row_t d;
    d.order = order;
    d.stim.action = act;
    d.stim.row_in = row;
    d.stim.col_in = col;
    d.stim.position_in = pos;
    d.known = known;
    d.res = res;
    dir_rows.push_back(d);
  endtask

  // mostly cells and positions inside the grid, some at its edge, some anywhere
  function automatic hcm_pkg::hcm_in_t random_item(input logic [hcm_pkg::ORDER_W-1:0] raw);
    hcm_pkg::hcm_in_t it;
    int               n;
    int               sel;
    logic [16:0]      cmask;
    logic [32:0]      pmask;
    logic [15:0]      tmp;
    n = grid_order(raw);
    cmask = (17'd1 << n) - 17'd1;
    pmask = (33'd1 << (2 * n)) - 33'd1;
    it.action = ($urandom_range(0, 1) != 0) ? hcm_pkg::ACT_D2XY : hcm_pkg::ACT_XY2D;
    it.row_in = 16'($urandom);
    it.col_in = 16'($urandom);
    it.position_in = $urandom;
    sel = $urandom_range(0, 99);
    if (sel < 80) begin
      it.row_in &= cmask[15:0];
      it.col_in &= cmask[15:0];
      it.position_in &= pmask[31:0];
    end else if (sel < 92) begin
      it.row_in = cmask[15:0] + 16'($urandom_range(0, 1));
      it.col_in &= cmask[15:0];
      if ($urandom_range(0, 1) != 0) begin
        tmp = it.row_in;
        it.row_in = it.col_in;
        it.col_in = tmp;
      end
      it.position_in = pmask[31:0] + 32'($urandom_range(0, 1));
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic report(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("ERROR: %s", msg);
  endtask

  task automatic send(input hcm_pkg::hcm_in_t it, input bit known,
                      input hcm_pkg::hcm_out_t res);
    in_data = it;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_results.push_back(known ? res : hilbert_convert(it, cur_order));
    sent++;
    @(negedge clk);
  endtask

  task automatic idle_after_send();
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // only with the pipeline empty: drain, wait out the latency, then write
  task automatic set_order(input logic [hcm_pkg::ORDER_W-1:0] v);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_data = v;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_order = v;
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  always @(negedge clk) begin
    int r;
    if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if (!steady) begin
        r = $urandom_range(0, 99);
        if (r < 20) stall_left = $urandom_range(1, 3);
        else if (r < 23) stall_left = $urandom_range(8, 30);
      end
    end
  end

  always @(posedge clk) begin
    hcm_pkg::hcm_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report($sformatf("result with nothing outstanding: %h", out_data));
      end else begin
        want = expected_results.pop_front();
        checked++;
        if (want.out_of_range) flagged++;
        if (out_data.position_out !== want.position_out)
          report($sformatf("position_out %h, want %h", out_data.position_out, want.position_out));
        if (out_data.row_out !== want.row_out)
          report($sformatf("row_out %h, want %h", out_data.row_out, want.row_out));
        if (out_data.col_out !== want.col_out)
          report($sformatf("col_out %h, want %h", out_data.col_out, want.col_out));
        if (out_data.out_of_range !== want.out_of_range)
          report($sformatf("out_of_range %b, want %b", out_data.out_of_range,
                           want.out_of_range));
      end
    end
  end

  initial begin
    #6000000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    logic [hcm_pkg::ORDER_W-1:0] ph_order;
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    cur_order = hcm_pkg::ORDER_RESET;
    steady = 1'b0;
    sent = 0;
    cfg_writes = 0;

    // order 5 straight out of reset
    add_row(5, hcm_pkg::ACT_XY2D, 0, 0, 0, 1, outcome(0, 0, 0, 0));
    add_row(5, hcm_pkg::ACT_D2XY, 0, 0, 0, 1, outcome(0, 0, 0, 0));
    add_row(5, hcm_pkg::ACT_D2XY, 0, 0, 1023, 1, outcome(0, 31, 0, 0));
    add_row(5, hcm_pkg::ACT_XY2D, 31, 0, 0, 1, outcome(1023, 0, 0, 0));
    add_row(5, hcm_pkg::ACT_XY2D, 32, 0, 0, 1, outcome(0, 0, 0, 1));
    add_row(5, hcm_pkg::ACT_XY2D, 0, 16'hffff, 0, 1, outcome(0, 0, 0, 1));
    add_row(5, hcm_pkg::ACT_D2XY, 0, 0, 1024, 1, outcome(0, 0, 0, 1));
    add_row(5, hcm_pkg::ACT_D2XY, 16'hffff, 16'hffff, 32'hffffffff, 1, outcome(0, 0, 0, 1));
    // fields the action does not use are ignored
    add_row(5, hcm_pkg::ACT_XY2D, 7, 9, 32'hffffffff, 0, '0);
    add_row(5, hcm_pkg::ACT_D2XY, 16'hffff, 16'hffff, 555, 0, '0);
    // order 1 is the base shape itself
    add_row(1, hcm_pkg::ACT_XY2D, 0, 1, 0, 1, outcome(1, 0, 0, 0));
    add_row(1, hcm_pkg::ACT_XY2D, 1, 1, 0, 1, outcome(2, 0, 0, 0));
    add_row(1, hcm_pkg::ACT_XY2D, 1, 0, 0, 1, outcome(3, 0, 0, 0));
    add_row(1, hcm_pkg::ACT_D2XY, 0, 0, 2, 1, outcome(0, 1, 1, 0));
    add_row(1, hcm_pkg::ACT_D2XY, 0, 0, 4, 1, outcome(0, 0, 0, 1));
    add_row(1, hcm_pkg::ACT_XY2D, 2, 0, 0, 1, outcome(0, 0, 0, 1));
    // zero order behaves as order 1
    add_row(0, hcm_pkg::ACT_XY2D, 1, 0, 0, 1, outcome(3, 0, 0, 0));
    add_row(0, hcm_pkg::ACT_D2XY, 0, 0, 4, 1, outcome(0, 0, 0, 1));
    // full 16-bit grid, every position in range
    add_row(16, hcm_pkg::ACT_XY2D, 16'hffff, 16'hffff, 0, 0, '0);
    add_row(16, hcm_pkg::ACT_D2XY, 0, 0, 32'hffffffff, 1, outcome(0, 16'hffff, 0, 0));
    add_row(16, hcm_pkg::ACT_XY2D, 16'hffff, 0, 0, 1, outcome(32'hffffffff, 0, 0, 0));
    // orders above the cap clamp to 16
    add_row(31, hcm_pkg::ACT_D2XY, 0, 0, 32'hffffffff, 1, outcome(0, 16'hffff, 0, 0));
    add_row(17, hcm_pkg::ACT_XY2D, 0, 0, 0, 1, outcome(0, 0, 0, 0));

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].order != cur_order) set_order(dir_rows[i].order);
      send(dir_rows[i].stim, dir_rows[i].known, dir_rows[i].res);
      idle_after_send();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ph_order = 16;
        1: ph_order = 2;
        2: ph_order = hcm_pkg::ORDER_W'($urandom_range(3, 15));
        3: ph_order = 1;
        4: ph_order = hcm_pkg::ORDER_W'($urandom_range(17, 31));
        5: ph_order = hcm_pkg::ORDER_W'($urandom_range(0, 31));
        default: ph_order = 5;
      endcase
      set_order(ph_order);
      steady = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // short bursts at full rate inside otherwise bursty phases
        if (!steady && $urandom_range(0, 49) == 0) steady = 1'b1;
        else if (steady && $urandom_range(0, 39) == 0) steady = 1'b0;
        send(random_item(cur_order), 0, '0);
        idle_after_send();
      end
    end

    in_valid = 1'b0;
    steady = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("checked %0d conversions (%0d out of grid) across %0d order writes,",
             checked, flagged, cfg_writes);
    $display("including orders 0, 1, 16 and clamped values above 16");
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
